[design/http_header_line_parser_unit_macros.svh]
// Assertion macros for the header line parser checker.
// Needs nothing; included by the checker file.
`ifndef HTTP_HEADER_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define HHLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("header parser check failed: implication");

// Signal holds over a cycle in which the condition is true.
`define HHLP_ASSERT_HOLDS(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> $stable(sig)) \
		else $error("header parser check failed: stalled signal moved");

`endif

[design/hhlp_pkg.sv]
// Shared types and constants of the HTTP header line parser.
// No dependencies; used by hhlp_step, the top level and the checker.
`default_nettype none

package hhlp_pkg;

	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_KEY    = 4'd1;
	localparam logic [3:0] PH_COLON  = 4'd2;
	localparam logic [3:0] PH_SPACE  = 4'd3;
	localparam logic [3:0] PH_VALUE  = 4'd4;
	localparam logic [3:0] PH_CR     = 4'd5;
	localparam logic [3:0] PH_LF     = 4'd6;
	localparam logic [3:0] PH_END_CR = 4'd7;
	localparam logic [3:0] PH_END_LF = 4'd8;

	localparam logic [2:0] ROLE_SKIP  = 3'd0;
	localparam logic [2:0] ROLE_KEY   = 3'd1;
	localparam logic [2:0] ROLE_SEP   = 3'd2;
	localparam logic [2:0] ROLE_VALUE = 3'd3;
	localparam logic [2:0] ROLE_EOL   = 3'd4;
	localparam logic [2:0] ROLE_BODY  = 3'd5;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [9:0] MAX_VALUE_RESET = 10'd255;

	typedef struct packed {
		logic [3:0]  phase;
		logic [10:0] count;
		logic        err;
		logic        done;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic        key_complete;
		logic        pair_complete;
		logic [10:0] value_count;
		logic        parse_error;
		logic        section_done;
	} parse_result_t;

endpackage

`default_nettype wire

[design/hhlp_if.sv]
// Handshake channel interfaces of the header line parser.
// No dependencies; instanced by the bench and taken by the top level.
`default_nettype none

interface hhlp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, data_byte, restart, input ready);
	modport sink (input valid, data_byte, restart, output ready);
endinterface

interface hhlp_role_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic        key_complete;
	logic        pair_complete;
	logic [10:0] value_count;
	logic        parse_error;
	logic        section_done;

	modport source (output valid, byte_role, key_complete, pair_complete, value_count,
		parse_error, section_done, input ready);
	modport sink (input valid, byte_role, key_complete, pair_complete, value_count,
		parse_error, section_done, output ready);
endinterface

interface hhlp_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[design/hhlp_step.sv]
// Next-state and result logic for one header byte.
// Depends on hhlp_pkg.
`default_nettype none

module hhlp_step (
	input  wire hhlp_pkg::parse_state_t  cur,
	input  wire logic [7:0]              data_byte,
	input  wire logic                    restart,
	input  wire logic [9:0]              max_len,
	output hhlp_pkg::parse_state_t       nxt,
	output hhlp_pkg::parse_result_t      res
);

	hhlp_pkg::parse_state_t st;
	logic [2:0] role;
	logic       keyc;
	logic       pairc;
	logic       fail;
	logic       is_cr;
	logic       is_lf;

	assign is_cr = (data_byte == hhlp_pkg::CH_CR);
	assign is_lf = (data_byte == hhlp_pkg::CH_LF);

	always_comb begin
		// restart wipes the parse state ahead of this byte
		st    = restart ? '0 : cur;
		nxt   = st;
		role  = hhlp_pkg::ROLE_SKIP;
		keyc  = 1'b0;
		pairc = 1'b0;
		fail  = 1'b0;
		if (st.err) begin
			role = hhlp_pkg::ROLE_SKIP;
		end else if (st.done) begin
			role = hhlp_pkg::ROLE_BODY;
		end else begin
			unique case (st.phase)
				hhlp_pkg::PH_KEY: begin
					if (data_byte == hhlp_pkg::CH_COLON) begin
						role      = hhlp_pkg::ROLE_SEP;
						keyc      = 1'b1;
						nxt.phase = hhlp_pkg::PH_COLON;
					end else if (is_cr || is_lf) begin
						fail = 1'b1;
					end else begin
						role = hhlp_pkg::ROLE_KEY;
					end
				end
				hhlp_pkg::PH_COLON: begin
					if (data_byte == hhlp_pkg::CH_SPACE) begin
						role      = hhlp_pkg::ROLE_SEP;
						nxt.phase = hhlp_pkg::PH_SPACE;
					end else begin
						fail = 1'b1;
					end
				end
				hhlp_pkg::PH_SPACE: begin
					role      = hhlp_pkg::ROLE_VALUE;
					nxt.count = 11'd1;
					nxt.phase = hhlp_pkg::PH_VALUE;
				end
				hhlp_pkg::PH_VALUE: begin
					if (is_cr) begin
						role      = hhlp_pkg::ROLE_EOL;
						nxt.phase = hhlp_pkg::PH_CR;
					end else if (st.count > {1'b0, max_len}) begin
						fail = 1'b1;
					end else begin
						role      = hhlp_pkg::ROLE_VALUE;
						nxt.count = st.count + 11'd1;
					end
				end
				hhlp_pkg::PH_CR: begin
					if (is_lf) begin
						role      = hhlp_pkg::ROLE_EOL;
						pairc     = 1'b1;
						nxt.phase = hhlp_pkg::PH_LF;
					end else begin
						fail = 1'b1;
					end
				end
				hhlp_pkg::PH_LF: begin
					if (is_cr) begin
						role      = hhlp_pkg::ROLE_EOL;
						nxt.phase = hhlp_pkg::PH_END_CR;
					end else begin
						role      = hhlp_pkg::ROLE_KEY;
						nxt.count = '0;
						nxt.phase = hhlp_pkg::PH_KEY;
					end
				end
				hhlp_pkg::PH_END_CR: begin
					if (is_lf) begin
						role      = hhlp_pkg::ROLE_EOL;
						nxt.phase = hhlp_pkg::PH_END_LF;
						nxt.done  = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				hhlp_pkg::PH_END_LF: begin
					role = hhlp_pkg::ROLE_BODY;
				end
				default: begin
					// start phase; stray line ends before the first key are skipped
					if (!is_cr && !is_lf) begin
						role      = hhlp_pkg::ROLE_KEY;
						nxt.count = '0;
						nxt.phase = hhlp_pkg::PH_KEY;
					end
				end
			endcase
			if (fail) begin
				role    = hhlp_pkg::ROLE_SKIP;
				keyc    = 1'b0;
				pairc   = 1'b0;
				nxt     = st;
				nxt.err = 1'b1;
			end
		end
		res.byte_role     = role;
		res.key_complete  = keyc;
		res.pair_complete = pairc;
		res.value_count   = nxt.count;
		res.parse_error   = nxt.err;
		res.section_done  = nxt.done;
	end

endmodule

`default_nettype wire

[design/http_header_line_parser_unit.sv]
// Top level of the HTTP header line parser: byte register, step logic, result register.
// Depends on hhlp_pkg, hhlp_if.sv and hhlp_step.
//
// channel  modport  moves per transaction
// -------  -------  ------------------------------------------------------------
// bytes    sink     one header byte plus restart flag
// roles    source   role, key/pair strobes, value count, error and done flags
// cfg      sink     max_value_length (10 bits), always ready
//
// One byte per cycle sustained while roles is ready; a taken byte sits in the byte register
// and its result in the result register, from where it can be taken.
// The rate is set by the single phase update, done as the byte register moves into
// the result register, so the parse state advances once per transaction.
// A stall on roles holds the result register; bytes stays ready while the byte
// register is empty or about to move, so one byte can be held behind a waiting result.
// arst_n clears both valid flags and the parse state; max_value_length returns to 255.
`default_nettype none

module http_header_line_parser_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	hhlp_byte_if.sink bytes,
	hhlp_role_if.source roles,
	hhlp_cfg_if.sink  cfg
);

	// byte register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       restart_s1;

	// result register
	logic                    valid_s2;
	hhlp_pkg::parse_result_t res_s2;

	// parse state and configuration
	hhlp_pkg::parse_state_t state_q;
	logic [9:0]             max_len_q;

	hhlp_pkg::parse_state_t  state_nxt;
	hhlp_pkg::parse_result_t res_nxt;

	logic s2_free;
	logic advance;

	assign s2_free   = !valid_s2 || roles.ready;
	assign advance   = valid_s1 && s2_free;
	assign bytes.ready = !valid_s1 || s2_free;
	assign cfg.ready = 1'b1;

	hhlp_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.max_len   (max_len_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// payload of the byte register needs no reset
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1    <= bytes.data_byte;
			restart_s1 <= bytes.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	// state moves only when a byte is handed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= hhlp_pkg::PH_START;
			state_q.count <= '0;
			state_q.err   <= 1'b0;
			state_q.done  <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= hhlp_pkg::MAX_VALUE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_len_q <= cfg.data;
		end
	end

	assign roles.valid         = valid_s2;
	assign roles.byte_role     = res_s2.byte_role;
	assign roles.key_complete  = res_s2.key_complete;
	assign roles.pair_complete = res_s2.pair_complete;
	assign roles.value_count   = res_s2.value_count;
	assign roles.parse_error   = res_s2.parse_error;
	assign roles.section_done  = res_s2.section_done;

endmodule

`default_nettype wire

[design/hhlp_checker.sv]
// Port-level checks of the header line parser, bound to the top level.
// Depends on hhlp_pkg and http_header_line_parser_unit_macros.svh.
`default_nettype none
`include "http_header_line_parser_unit_macros.svh"

module hhlp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  byte_role,
	input wire logic        key_complete,
	input wire logic        pair_complete,
	input wire logic [10:0] value_count,
	input wire logic        parse_error,
	input wire logic        section_done
);

	logic [17:0] payload;
	assign payload = {byte_role, key_complete, pair_complete, value_count,
		parse_error, section_done};

	`HHLP_ASSERT_HOLDS(a_stall_holds, clk, arst_n, out_valid && !out_ready, payload)

	`HHLP_ASSERT_IMPLIES(a_key_is_sep, clk, arst_n, out_valid && key_complete, byte_role == hhlp_pkg::ROLE_SEP)

	`HHLP_ASSERT_IMPLIES(a_pair_is_eol, clk, arst_n, out_valid && pair_complete, byte_role == hhlp_pkg::ROLE_EOL)

	`HHLP_ASSERT_IMPLIES(a_error_quiet, clk, arst_n, out_valid && parse_error, byte_role == hhlp_pkg::ROLE_SKIP && !key_complete && !pair_complete)

	`HHLP_ASSERT_IMPLIES(a_done_tail, clk, arst_n, out_valid && section_done && !parse_error, byte_role == hhlp_pkg::ROLE_EOL || byte_role == hhlp_pkg::ROLE_BODY)

endmodule

bind http_header_line_parser_unit hhlp_checker u_hhlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (roles.valid),
	.out_ready     (roles.ready),
	.byte_role     (roles.byte_role),
	.key_complete  (roles.key_complete),
	.pair_complete (roles.pair_complete),
	.value_count   (roles.value_count),
	.parse_error   (roles.parse_error),
	.section_done  (roles.section_done)
);

`default_nettype wire

[tb/hhlp_result_checker.sv]
// Scoreboard for the HTTP header line parser: follows the parse state from accepted bytes,
// predicts every role transaction and compares it with what the block sends.
// Depends on hhlp_pkg and the channel interfaces of hhlp_if.sv.
module hhlp_result_checker import hhlp_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	hhlp_byte_if bytes,
	hhlp_role_if roles,
	hhlp_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [3:0]    phase_q;
	logic [10:0]   count_q;
	logic          err_q;
	logic          done_q;
	logic [9:0]    limit_q;
	parse_result_t expected_roles[$];
	int            mismatches;

	// One header byte through the parse machine; updates the tracked state.
	function automatic parse_result_t parse_byte(input logic [7:0] b, input logic rs);
		parse_result_t r;
		logic bad;
		r = '0;
		bad = 1'b0;
		if (rs) begin
			phase_q = PH_START;
			count_q = '0;
			err_q = 1'b0;
			done_q = 1'b0;
		end
		if (err_q) begin
			r.byte_role = ROLE_SKIP;
		end else if (done_q) begin
			r.byte_role = ROLE_BODY;
		end else begin
			case (phase_q)
				PH_KEY: begin
					if (b == CH_COLON) begin
						r.byte_role = ROLE_SEP;
						r.key_complete = 1'b1;
						phase_q = PH_COLON;
					end else if (b == CH_CR || b == CH_LF) begin
						bad = 1'b1;
					end else begin
						r.byte_role = ROLE_KEY;
					end
				end
				PH_COLON: begin
					if (b == CH_SPACE) begin
						r.byte_role = ROLE_SEP;
						phase_q = PH_SPACE;
					end else begin
						bad = 1'b1;
					end
				end
				PH_SPACE: begin
					r.byte_role = ROLE_VALUE;
					count_q = 11'd1;
					phase_q = PH_VALUE;
				end
				PH_VALUE: begin
					if (b == CH_CR) begin
						r.byte_role = ROLE_EOL;
						phase_q = PH_CR;
					end else if (count_q > {1'b0, limit_q}) begin
						bad = 1'b1;
					end else begin
						r.byte_role = ROLE_VALUE;
						count_q = count_q + 11'd1;
					end
				end
				PH_CR: begin
					if (b == CH_LF) begin
						r.byte_role = ROLE_EOL;
						r.pair_complete = 1'b1;
						phase_q = PH_LF;
					end else begin
						bad = 1'b1;
					end
				end
				PH_LF: begin
					if (b == CH_CR) begin
						r.byte_role = ROLE_EOL;
						phase_q = PH_END_CR;
					end else begin
						r.byte_role = ROLE_KEY;
						count_q = '0;
						phase_q = PH_KEY;
					end
				end
				PH_END_CR: begin
					if (b == CH_LF) begin
						r.byte_role = ROLE_EOL;
						phase_q = PH_END_LF;
						done_q = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				PH_END_LF: r.byte_role = ROLE_BODY;
				default: begin
					// start phase: leading line ends are skipped
					if (b != CH_CR && b != CH_LF) begin
						r.byte_role = ROLE_KEY;
						count_q = '0;
						phase_q = PH_KEY;
					end
				end
			endcase
			if (bad) begin
				r.byte_role = ROLE_SKIP;
				r.key_complete = 1'b0;
				r.pair_complete = 1'b0;
				err_q = 1'b1;
			end
		end
		r.value_count = count_q;
		r.parse_error = err_q;
		r.section_done = done_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t got;
		parse_result_t want;
		logic bad;
		if (!arst_n) begin
			phase_q = PH_START;
			count_q = '0;
			err_q = 1'b0;
			done_q = 1'b0;
			limit_q = MAX_VALUE_RESET;
			expected_roles.delete();
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				limit_q = cfg.data;
			if (roles.valid && roles.ready) begin
				got = '{roles.byte_role, roles.key_complete, roles.pair_complete,
					roles.value_count, roles.parse_error, roles.section_done};
				if (expected_roles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("checker: unexpected role transaction, role %0d count %0d",
							got.byte_role, got.value_count);
				end else begin
					want = expected_roles.pop_front();
					bad = (got.byte_role !== want.byte_role)
						|| (got.key_complete !== want.key_complete)
						|| (got.pair_complete !== want.pair_complete)
						|| (got.value_count !== want.value_count)
						|| (got.parse_error !== want.parse_error)
						|| (got.section_done !== want.section_done);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"checker: mismatch, expected role %0d key %0b pair %0b ",
								"count %0d err %0b done %0b, got role %0d key %0b pair %0b ",
								"count %0d err %0b done %0b"},
								want.byte_role, want.key_complete, want.pair_complete,
								want.value_count, want.parse_error, want.section_done,
								got.byte_role, got.key_complete, got.pair_complete,
								got.value_count, got.parse_error, got.section_done);
					end
				end
			end
			if (bytes.valid && bytes.ready)
				expected_roles.push_back(parse_byte(bytes.data_byte, bytes.restart));
		end
		fail_count <= mismatches;
		pending <= expected_roles.size();
	end

endmodule

[tb/tb_http_header_line_parser_unit.sv]
// Top of the header line parser bench: clock, reset, byte and register stimulus, verdict.
// Depends on hhlp_pkg, hhlp_if.sv, the parser top level and hhlp_result_checker.
module tb_http_header_line_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import hhlp_pkg::*;

	// generous: well above what the whole run needs
	localparam int CYCLE_LIMIT = 200000;
	// random bytes per register setting; with the opening and the long value,
	// about 1650 in all
	localparam int PHASE_ITEMS = 80;

	// directed opening: {restart, byte}
	localparam logic [8:0] OPENING [25] = '{
		{1'b1, CH_LF},    // leading line ends are skipped
		{1'b0, CH_CR},
		{1'b0, 8'hFF},    // key bytes at both extremes
		{1'b0, 8'h00},
		{1'b0, CH_COLON}, // key complete
		{1'b0, CH_SPACE},
		{1'b0, CH_CR},    // first value byte is taken whatever it is
		{1'b0, 8'hFF},
		{1'b0, CH_CR},    // value ends, CR not counted
		{1'b0, CH_LF},    // pair complete
		{1'b0, CH_COLON}, // colon opening a key is a key byte, count back to zero
		{1'b0, CH_COLON},
		{1'b0, CH_SPACE},
		{1'b0, 8'h76},
		{1'b0, CH_CR},
		{1'b0, CH_LF},
		{1'b0, CH_CR},    // blank line
		{1'b0, CH_LF},    // section done
		{1'b0, 8'h00},    // body
		{1'b1, 8'h6B},
		{1'b0, CH_CR},    // bare CR inside a key
		{1'b0, 8'h78},    // ignored after the error
		{1'b1, 8'h6B},
		{1'b0, CH_COLON},
		{1'b0, 8'h78}     // no space after the colon
	};

	logic       clk = 1'b0;
	logic       arst_n;
	int         idle_pct = 8;
	int         stall_pct = 8;
	int         cycle_count = 0;
	int         fail_count;
	int         pending;
	int         sent;
	logic [9:0] value_limit;

	hhlp_byte_if bytes();
	hhlp_role_if roles();
	hhlp_cfg_if  cfg();

	http_header_line_parser_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.roles  (roles),
		.cfg    (cfg)
	);

	hhlp_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.roles      (roles),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: stalls at random, held low through reset
	initial begin
		roles.ready = 1'b0;
		forever begin
			@(posedge clk);
			roles.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [7:0] value_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR);
		return b;
	endfunction

	// One byte transaction, with random idle cycles in front of it.
	// valid is left high afterwards so back-to-back bytes see no gap.
	task automatic send_byte(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < idle_pct) begin
			bytes.valid <= 1'b0;
			@(posedge clk);
		end
		bytes.valid <= 1'b1;
		bytes.data_byte <= b;
		bytes.restart <= rs;
		do @(posedge clk); while (!bytes.ready);
	endtask

	// Drop valid, wait until every predicted role transaction has come back, then settle.
	// pending is a registered copy, hence the edge before the loop.
	task automatic drain(input int settle);
		bytes.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_limit(input logic [9:0] v);
		drain(4);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		value_limit = v;
	endtask

	// One header section: mostly well formed with random content, some with one
	// corrupted byte, a few pure noise. Bytes after a corruption mostly fall on an
	// errored parser, so they are not counted.
	task automatic send_section();
		logic [7:0] sect[$];
		logic [7:0] b;
		int kind;
		int cut;
		int len;
		kind = $urandom_range(99);
		if (kind < 5) begin
			repeat ($urandom_range(20, 4)) sect.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(2)) sect.push_back($urandom_range(1) ? CH_CR : CH_LF);
			repeat ($urandom_range(4, 1)) begin
				repeat ($urandom_range(6, 1)) begin
					do b = 8'($urandom_range(255));
					while (b == CH_COLON || b == CH_CR || b == CH_LF);
					sect.push_back(b);
				end
				sect.push_back(CH_COLON);
				sect.push_back(CH_SPACE);
				// small limits: aim at the edge, one byte either side of overflow
				if (value_limit <= 40 && $urandom_range(3) == 0)
					len = $urandom_range(value_limit + 2, (value_limit == 0) ? 1 : value_limit);
				else
					len = $urandom_range(12, 1);
				sect.push_back(($urandom_range(9) == 0) ? CH_CR : 8'($urandom_range(255)));
				repeat (len - 1) sect.push_back(value_byte());
				sect.push_back(CH_CR);
				sect.push_back(CH_LF);
			end
			sect.push_back(CH_CR);
			sect.push_back(CH_LF);
			repeat ($urandom_range(3)) sect.push_back(8'($urandom_range(255)));
		end
		cut = sect.size();
		if (kind >= 5 && kind < 20) begin
			cut = $urandom_range(sect.size() - 1);
			case ($urandom_range(4))
				0: sect[cut] = CH_CR;
				1: sect[cut] = CH_LF;
				2: sect[cut] = CH_COLON;
				3: sect[cut] = CH_SPACE;
				default: sect[cut] = 8'($urandom_range(255));
			endcase
		end
		// restart on the first byte as a rule, now and then mid-section too
		foreach (sect[i]) begin
			send_byte(sect[i], (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0));
			if (i <= cut)
				sent++;
		end
	endtask

	initial begin
		logic [9:0] plan [6];
		arst_n = 1'b0;
		bytes.valid = 1'b0;
		bytes.data_byte = '0;
		bytes.restart = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		value_limit = MAX_VALUE_RESET;
		// reset value first, then both extremes, then small and random limits
		plan = '{MAX_VALUE_RESET, 10'd0, 10'd1023, 10'd1,
			10'($urandom_range(40, 2)), 10'($urandom_range(1023))};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i])
			send_byte(OPENING[i][7:0], OPENING[i][8]);

		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				write_limit(plan[p]);
			// the widest limit runs with no idling on either side
			idle_pct = (p == 2) ? 0 : 8;
			stall_pct = idle_pct;
			sent = 0;
			while (sent < PHASE_ITEMS)
				send_section();
			if (p == 2) begin
				// one value long enough to take the counter to 1024, then overflow
				send_byte(8'h4B, 1'b1);
				send_byte(CH_COLON, 1'b0);
				send_byte(CH_SPACE, 1'b0);
				repeat (1025) send_byte(value_byte(), 1'b0);
			end
		end

		drain(8);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
